/* src/assert_macros.svh */
// Assertion macros shared by the challenge sampler modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under synchronous active-low reset.
`define CHC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under synchronous active-low reset.
`define CHC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/chc_pkg.sv */
// Constants, types and helpers of the challenge sampler.
`timescale 1ns / 1ps

package chc_pkg;

  localparam int ROUNDS      = 64;
  localparam int FIXED_COUNT = 16;
  localparam int BOUND       = 16;

  localparam int POS_W = 6;
  localparam int VAL_W = 5;

  localparam int IDX_W    = $clog2(ROUNDS);
  localparam int CNT_W    = $clog2(ROUNDS + 1);
  localparam int VAL_NEED = $clog2(BOUND);
  localparam int MAX_NEED = (IDX_W > VAL_NEED) ? IDX_W : VAL_NEED;
  localparam int NEED_W   = $clog2(MAX_NEED + 1);
  localparam int BUF_W    = MAX_NEED + 7;
  localparam int BCNT_W   = $clog2(BUF_W + 1);

  // Scheme: place the bound entries first when they are the smaller set.
  localparam bit BOUND_FIRST = (ROUNDS - FIXED_COUNT) < FIXED_COUNT;
  localparam int PLACE_CNT   = BOUND_FIRST ?
                               ((ROUNDS > FIXED_COUNT) ? (ROUNDS - FIXED_COUNT) : 0) :
                               FIXED_COUNT;

  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [NEED_W-1:0]   need_t;
  typedef logic [BCNT_W-1:0]   bcnt_t;
  typedef logic [BUF_W-1:0]    buf_t;
  typedef logic [MAX_NEED-1:0] bits_t;
  typedef logic [VAL_W-1:0]    val_t;
  typedef logic [VAL_NEED:0]   vcmp_t;
  typedef logic [POS_W-1:0]    pos_t;

  localparam cnt_t  ROUNDS_CNT = cnt_t'(ROUNDS);
  localparam cnt_t  PLACE_LIM  = cnt_t'(PLACE_CNT);
  localparam idx_t  LAST_IDX   = idx_t'(ROUNDS - 1);
  localparam need_t VAL_NEED_N = need_t'(VAL_NEED);
  localparam vcmp_t BOUND_CMP  = vcmp_t'(BOUND);
  localparam val_t  BOUND_LO   = val_t'(BOUND);

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_BYTE  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_SCAN,
    ST_EMIT_RD,
    ST_EMIT_OUT,
    ST_DONE
  } st_t;

  typedef enum logic {
    PH_PLACE,
    PH_VALUE
  } ph_t;

  typedef struct packed {
    logic  clear;
    logic  load;
    logic  [7:0] data;
    logic  take;
    need_t need;
  } bb_ctl_t;

  typedef struct packed {
    logic clear;
    logic start;
    cnt_t start_idx;
    idx_t rem;
    logic mark;
  } scan_cmd_t;

  typedef struct packed {
    logic done;
    logic found;
    idx_t idx;
  } scan_sts_t;

  // Smallest s >= 1 with 2^s >= span.
  function automatic need_t need_bits(input cnt_t span);
    cnt_t  sm1;
    need_t s;
    sm1 = span - cnt_t'(1);
    s   = need_t'(1);
    for (int i = 1; i < CNT_W; i++) begin
      if ((sm1 >> i) != '0) begin
        s = need_t'(i + 1);
      end
    end
    return s;
  endfunction

endpackage

/* src/chc_bitbuf.sv */
// Random bit buffer: bytes enter at the low end, draws leave from the low end.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module chc_bitbuf (
  input  logic             clk,
  input  logic             rst_n,
  input  chc_pkg::bb_ctl_t ctl,
  output chc_pkg::bcnt_t   cnt,
  output chc_pkg::bits_t   bits
);

  chc_pkg::buf_t  buf_r, buf_nxt;
  chc_pkg::bcnt_t cnt_r, cnt_nxt;
  chc_pkg::bcnt_t need_ext;

  assign need_ext = chc_pkg::bcnt_t'(ctl.need);

  always_comb begin
    buf_nxt = buf_r;
    cnt_nxt = cnt_r;
    if (ctl.clear) begin
      buf_nxt = '0;
      cnt_nxt = '0;
    end else if (ctl.load) begin
      buf_nxt = (buf_r << 8) | chc_pkg::buf_t'(ctl.data);
      cnt_nxt = cnt_r + chc_pkg::bcnt_t'(8);
    end else if (ctl.take) begin
      buf_nxt = buf_r >> ctl.need;
      cnt_nxt = cnt_r - need_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r <= '0;
      cnt_r <= '0;
    end else begin
      buf_r <= buf_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign cnt  = cnt_r;
  assign bits = buf_r[chc_pkg::MAX_NEED-1:0];

  `CHC_ASSERT_IMPL(a_take_has_bits, clk, rst_n, ctl.take, cnt_r >= need_ext, "draw without enough bits")
  `CHC_ASSERT_IMPL(a_load_xor_take, clk, rst_n, ctl.load, !ctl.take, "load and draw in one cycle")

endmodule

/* src/chc_slots.sv */
// Slot marks and the shared scan unit that finds the r-th free slot.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module chc_slots (
  input  logic                  clk,
  input  logic                  rst_n,
  input  chc_pkg::scan_cmd_t    cmd,
  input  chc_pkg::idx_t         emit_idx,
  output chc_pkg::scan_sts_t    sts,
  output logic                  emit_mark
);

  logic [chc_pkg::ROUNDS-1:0] marks_r, marks_nxt;
  logic                       busy_r, busy_nxt;
  logic                       mark_r, mark_nxt;
  chc_pkg::cnt_t              idx_r, idx_nxt;
  chc_pkg::idx_t              rem_r, rem_nxt;
  chc_pkg::idx_t              idx_lo;
  logic                       at_end, free, hit, done;

  assign idx_lo = idx_r[chc_pkg::IDX_W-1:0];
  assign at_end = (idx_r == chc_pkg::ROUNDS_CNT);
  assign free   = !at_end && !marks_r[idx_lo];
  assign hit    = free && (rem_r == '0);
  assign done   = busy_r && (at_end || hit);

  always_comb begin
    marks_nxt = marks_r;
    busy_nxt  = busy_r;
    mark_nxt  = mark_r;
    idx_nxt   = idx_r;
    rem_nxt   = rem_r;
    if (cmd.clear) begin
      marks_nxt = '0;
      busy_nxt  = 1'b0;
    end else if (cmd.start) begin
      busy_nxt = 1'b1;
      mark_nxt = cmd.mark;
      idx_nxt  = cmd.start_idx;
      rem_nxt  = cmd.rem;
    end else if (busy_r) begin
      if (done) begin
        busy_nxt = 1'b0;
        if (hit && mark_r) begin
          marks_nxt[idx_lo] = 1'b1;
        end
      end else begin
        // skip marked slots, count down on free ones
        if (free) begin
          rem_nxt = rem_r - chc_pkg::idx_t'(1);
        end
        idx_nxt = idx_r + chc_pkg::cnt_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marks_r <= '0;
      busy_r  <= 1'b0;
      mark_r  <= 1'b0;
    end else begin
      marks_r <= marks_nxt;
      busy_r  <= busy_nxt;
      mark_r  <= mark_nxt;
    end
    idx_r <= idx_nxt;
    rem_r <= rem_nxt;
  end

  assign sts.done  = done;
  assign sts.found = done && !at_end;
  assign sts.idx   = idx_lo;
  assign emit_mark = marks_r[emit_idx];

  `CHC_ASSERT_IMPL(a_scan_in_range, clk, rst_n, busy_r, idx_r <= chc_pkg::ROUNDS_CNT, "scan index past end")
  `CHC_ASSERT_NEXT(a_scan_ends, clk, rst_n, done, !busy_r, "scan still busy after done")

endmodule

/* src/chc_store.sv */
// Entry value memory: one write port, one registered read port.
`timescale 1ns / 1ps

module chc_store (
  input  logic          clk,
  input  logic          wr_en,
  input  chc_pkg::idx_t wr_addr,
  input  chc_pkg::val_t wr_data,
  input  logic          rd_en,
  input  chc_pkg::idx_t rd_addr,
  output chc_pkg::val_t rd_data
);

  chc_pkg::val_t mem [chc_pkg::ROUNDS];
  chc_pkg::val_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* src/challenge_sampler_from_random_bytes.sv */
// Top level of the fixed-weight challenge sampler: sequencer and channels.
//
// Input channel (in_valid/in_ready): a request with in_func = 0 starts a new
// challenge and clears the bit buffer, slot marks and counters.
// A request with in_func = 1 delivers in_random_byte to the bit buffer; the
// sequencer then draws positions and values until the buffer runs short.
// A value draw is made in ST_STEP alone; a position draw adds a scan over the
// slots (ST_SCAN), which sets the per-byte time; in_ready is low meanwhile.
// When the byte that completes the challenge has been used, the block sends
// ROUNDS results on the output channel (out_valid/out_ready), positions in
// increasing order, out_last on the final one. Each result is read from memory
// (ST_EMIT_RD), then shown on the output (ST_EMIT_OUT), where it holds while
// out_ready is low and nothing advances. After the last result bytes are taken
// and dropped until a start request arrives.
// Reset (rst_n low, synchronous) gives the same state as a start request.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module challenge_sampler_from_random_bytes (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_func,
  input  logic [7:0]           in_random_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output chc_pkg::pos_t        out_position,
  output logic                 out_is_bound,
  output chc_pkg::val_t        out_value,
  output logic                 out_last
);

  chc_pkg::st_t  st_r, st_nxt;
  chc_pkg::ph_t  ph_r, ph_nxt;
  chc_pkg::cnt_t placed_r, placed_nxt;
  chc_pkg::cnt_t fill_r, fill_nxt;
  logic          fill_ok_r, fill_ok_nxt;
  chc_pkg::idx_t emit_r, emit_nxt;

  chc_pkg::bb_ctl_t   bb_ctl;
  chc_pkg::bcnt_t     bb_cnt;
  chc_pkg::bits_t     bb_bits;
  chc_pkg::scan_cmd_t scan_cmd;
  chc_pkg::scan_sts_t scan_sts;
  logic               emit_mark;

  logic          st_wr_en, st_rd_en;
  chc_pkg::val_t st_wr_data, st_rd_data;

  chc_pkg::cnt_t  span;
  chc_pkg::need_t pos_need;
  chc_pkg::idx_t  pos_r;
  chc_pkg::vcmp_t val_draw;
  logic           in_acc, clear;

  assign in_ready = (st_r == chc_pkg::ST_IDLE) || (st_r == chc_pkg::ST_DONE);
  assign in_acc   = in_valid && in_ready;
  assign clear    = in_acc && (in_func == chc_pkg::FUNC_START);

  assign span     = chc_pkg::ROUNDS_CNT - placed_r;
  assign pos_need = chc_pkg::need_bits(span);
  assign pos_r    = bb_bits[chc_pkg::IDX_W-1:0] & ~({chc_pkg::IDX_W{1'b1}} << pos_need);
  assign val_draw = chc_pkg::vcmp_t'(bb_bits[chc_pkg::VAL_NEED-1:0]);
  assign st_wr_data = chc_pkg::val_t'(bb_bits[chc_pkg::VAL_NEED-1:0]);

  always_comb begin
    st_nxt      = st_r;
    ph_nxt      = ph_r;
    placed_nxt  = placed_r;
    fill_nxt    = fill_r;
    fill_ok_nxt = fill_ok_r;
    emit_nxt    = emit_r;

    bb_ctl       = '0;
    bb_ctl.clear = clear;
    bb_ctl.data  = in_random_byte;
    scan_cmd       = '0;
    scan_cmd.clear = clear;
    st_wr_en = 1'b0;
    st_rd_en = 1'b0;

    case (st_r)
      chc_pkg::ST_IDLE, chc_pkg::ST_DONE: begin
        if (clear) begin
          st_nxt      = chc_pkg::ST_IDLE;
          ph_nxt      = chc_pkg::PH_PLACE;
          placed_nxt  = '0;
          fill_nxt    = '0;
          fill_ok_nxt = 1'b0;
        end else if (in_acc && st_r == chc_pkg::ST_IDLE) begin
          bb_ctl.load = 1'b1;
          st_nxt      = chc_pkg::ST_STEP;
        end
      end
      chc_pkg::ST_STEP: begin
        if (ph_r == chc_pkg::PH_PLACE) begin
          if (placed_r >= chc_pkg::PLACE_LIM) begin
            if (chc_pkg::BOUND_FIRST) begin
              ph_nxt      = chc_pkg::PH_VALUE;
              fill_nxt    = '0;
              fill_ok_nxt = 1'b0;
            end else begin
              emit_nxt = '0;
              st_nxt   = chc_pkg::ST_EMIT_RD;
            end
          end else if (bb_cnt < chc_pkg::bcnt_t'(pos_need)) begin
            st_nxt = chc_pkg::ST_IDLE;
          end else begin
            bb_ctl.take = 1'b1;
            bb_ctl.need = pos_need;
            // drop draws at or above the span and redraw
            if (chc_pkg::cnt_t'(pos_r) < span) begin
              scan_cmd.start     = 1'b1;
              scan_cmd.start_idx = '0;
              scan_cmd.rem       = pos_r;
              scan_cmd.mark      = 1'b1;
              st_nxt             = chc_pkg::ST_SCAN;
            end
          end
        end else begin
          if (chc_pkg::BOUND_FIRST && !fill_ok_r) begin
            // advance the fill index to the next free slot
            scan_cmd.start     = 1'b1;
            scan_cmd.start_idx = fill_r;
            scan_cmd.rem       = '0;
            scan_cmd.mark      = 1'b0;
            st_nxt             = chc_pkg::ST_SCAN;
          end else if (bb_cnt < chc_pkg::bcnt_t'(chc_pkg::VAL_NEED_N)) begin
            st_nxt = chc_pkg::ST_IDLE;
          end else begin
            bb_ctl.take = 1'b1;
            bb_ctl.need = chc_pkg::VAL_NEED_N;
            if (val_draw < chc_pkg::BOUND_CMP) begin
              st_wr_en = 1'b1;
              if (chc_pkg::BOUND_FIRST) begin
                fill_nxt    = fill_r + chc_pkg::cnt_t'(1);
                fill_ok_nxt = 1'b0;
              end else begin
                placed_nxt = placed_r + chc_pkg::cnt_t'(1);
                ph_nxt     = chc_pkg::PH_PLACE;
              end
            end
          end
        end
      end
      chc_pkg::ST_SCAN: begin
        if (scan_sts.done) begin
          st_nxt = chc_pkg::ST_STEP;
          if (ph_r == chc_pkg::PH_PLACE) begin
            if (chc_pkg::BOUND_FIRST) begin
              placed_nxt = placed_r + chc_pkg::cnt_t'(1);
            end else begin
              fill_nxt = chc_pkg::cnt_t'(scan_sts.idx);
              ph_nxt   = chc_pkg::PH_VALUE;
            end
          end else if (scan_sts.found) begin
            fill_nxt    = chc_pkg::cnt_t'(scan_sts.idx);
            fill_ok_nxt = 1'b1;
          end else begin
            emit_nxt = '0;
            st_nxt   = chc_pkg::ST_EMIT_RD;
          end
        end
      end
      chc_pkg::ST_EMIT_RD: begin
        st_rd_en = 1'b1;
        st_nxt   = chc_pkg::ST_EMIT_OUT;
      end
      chc_pkg::ST_EMIT_OUT: begin
        if (out_ready) begin
          if (emit_r == chc_pkg::LAST_IDX) begin
            st_nxt = chc_pkg::ST_DONE;
          end else begin
            emit_nxt = emit_r + chc_pkg::idx_t'(1);
            st_nxt   = chc_pkg::ST_EMIT_RD;
          end
        end
      end
      default: begin
        st_nxt = chc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= chc_pkg::ST_IDLE;
      ph_r      <= chc_pkg::PH_PLACE;
      placed_r  <= '0;
      fill_r    <= '0;
      fill_ok_r <= 1'b0;
      emit_r    <= '0;
    end else begin
      st_r      <= st_nxt;
      ph_r      <= ph_nxt;
      placed_r  <= placed_nxt;
      fill_r    <= fill_nxt;
      fill_ok_r <= fill_ok_nxt;
      emit_r    <= emit_nxt;
    end
  end

  chc_bitbuf u_bitbuf (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (bb_ctl),
    .cnt   (bb_cnt),
    .bits  (bb_bits)
  );

  chc_slots u_slots (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (scan_cmd),
    .emit_idx  (emit_r),
    .sts       (scan_sts),
    .emit_mark (emit_mark)
  );

  chc_store u_store (
    .clk     (clk),
    .wr_en   (st_wr_en),
    .wr_addr (fill_r[chc_pkg::IDX_W-1:0]),
    .wr_data (st_wr_data),
    .rd_en   (st_rd_en),
    .rd_addr (emit_r),
    .rd_data (st_rd_data)
  );

  assign out_valid    = (st_r == chc_pkg::ST_EMIT_OUT);
  assign out_is_bound = chc_pkg::BOUND_FIRST ? emit_mark : !emit_mark;
  assign out_value    = out_is_bound ? chc_pkg::BOUND_LO : st_rd_data;
  assign out_position = chc_pkg::pos_t'(emit_r);
  assign out_last     = (emit_r == chc_pkg::LAST_IDX);

  `CHC_ASSERT_IMPL(a_no_overlap, clk, rst_n, out_valid, !in_ready, "input taken during output")
  `CHC_ASSERT_NEXT(a_last_to_done, clk, rst_n, out_valid && out_ready && out_last, st_r == chc_pkg::ST_DONE, "no done after last result")

endmodule

/* sim/challenge_sampler_from_random_bytes_tb.sv */
// Testbench for the fixed-weight challenge sampler: random byte stream in, checked challenge out.
`timescale 1ns / 1ps

module challenge_sampler_from_random_bytes_tb;

  typedef struct {
    chc_pkg::pos_t position;
    logic          is_bound;
    chc_pkg::val_t value;
    logic          last;
  } chal_entry_t;

  class chc_challenge_board;
    localparam bit FEW_BOUND = (chc_pkg::ROUNDS - chc_pkg::FIXED_COUNT) < chc_pkg::FIXED_COUNT;
    localparam int SEATS = FEW_BOUND ?
                           ((chc_pkg::ROUNDS > chc_pkg::FIXED_COUNT) ?
                            chc_pkg::ROUNDS - chc_pkg::FIXED_COUNT : 0) :
                           chc_pkg::FIXED_COUNT;

    logic [63:0]  bit_pool;
    int           pool_bits;
    int           entry_val [chc_pkg::ROUNDS];
    bit           slot_taken [chc_pkg::ROUNDS];
    int           seated;
    int           fill_at;
    chc_pkg::ph_t stage;
    bit           complete;

    chal_entry_t pending_entries[$];
    int          accepted;
    int          checked;
    int          fails;

    function new();
      accepted = 0;
      checked  = 0;
      fails    = 0;
      clear();
    endfunction

    function void clear();
      bit_pool  = '0;
      pool_bits = 0;
      foreach (entry_val[i]) begin
        entry_val[i]  = 0;
        slot_taken[i] = 1'b0;
      end
      seated   = 0;
      fill_at  = 0;
      stage    = chc_pkg::PH_PLACE;
      complete = 1'b0;
    endfunction

    task report(string msg);
      fails++;
      $display("ERROR %0t: %s", $realtime, msg);
    endtask

    function int bits_needed(int limit);
      int s;
      s = 1;
      while (s < 40 && (64'd1 << s) < 64'(limit)) s++;
      return s;
    endfunction

    function logic [63:0] draw(int width);
      logic [63:0] r;
      r = bit_pool & ((64'd1 << width) - 64'd1);
      bit_pool  = bit_pool >> width;
      pool_bits = pool_bits - width;
      return r;
    endfunction

    // r-th free slot counted from index 0
    function int nth_free(logic [63:0] r);
      logic [63:0] left;
      left = r;
      for (int i = 0; i < chc_pkg::ROUNDS; i++) begin
        if (!slot_taken[i]) begin
          if (left == 0) return i;
          left--;
        end
      end
      return chc_pkg::ROUNDS - 1;
    endfunction

    // Advance the challenge by one accepted request.
    function void note_request(logic func, logic [7:0] data);
      bit          running;
      int          span;
      int          width;
      int          slot;
      logic [63:0] r;
      chal_entry_t e;
      bit          isb;
      accepted++;
      if (func == chc_pkg::FUNC_START) begin
        clear();
        return;
      end
      if (complete) return;
      bit_pool  = (bit_pool << 8) + 64'(data);
      pool_bits = pool_bits + 8;
      running   = 1'b1;
      while (running) begin
        if (complete) begin
          running = 1'b0;
        end else if (stage == chc_pkg::PH_PLACE) begin
          if (seated >= SEATS) begin
            if (FEW_BOUND) begin
              stage   = chc_pkg::PH_VALUE;
              fill_at = 0;
            end else begin
              complete = 1'b1;
            end
          end else begin
            span  = chc_pkg::ROUNDS - seated;
            width = bits_needed(span);
            if (pool_bits < width) begin
              running = 1'b0;
            end else begin
              r = draw(width);
              if (r < 64'(span)) begin
                slot = nth_free(r);
                slot_taken[slot] = 1'b1;
                if (FEW_BOUND) begin
                  seated++;
                end else begin
                  fill_at = slot;
                  stage   = chc_pkg::PH_VALUE;
                end
              end
            end
          end
        end else begin
          if (FEW_BOUND) begin
            while (fill_at < chc_pkg::ROUNDS && slot_taken[fill_at]) fill_at++;
          end
          if (FEW_BOUND && fill_at >= chc_pkg::ROUNDS) begin
            complete = 1'b1;
          end else begin
            width = bits_needed(chc_pkg::BOUND);
            if (pool_bits < width) begin
              running = 1'b0;
            end else begin
              r = draw(width);
              if (r < 64'(chc_pkg::BOUND)) begin
                if (fill_at < chc_pkg::ROUNDS) entry_val[fill_at] = int'(r);
                if (FEW_BOUND) begin
                  fill_at++;
                end else begin
                  seated++;
                  stage = chc_pkg::PH_PLACE;
                end
              end
            end
          end
        end
      end
      if (!complete) return;
      for (int i = 0; i < chc_pkg::ROUNDS; i++) begin
        isb        = FEW_BOUND ? slot_taken[i] : !slot_taken[i];
        e.position = chc_pkg::pos_t'(i);
        e.is_bound = isb;
        e.value    = chc_pkg::val_t'(isb ? chc_pkg::BOUND : entry_val[i]);
        e.last     = (i == chc_pkg::ROUNDS - 1);
        pending_entries.push_back(e);
      end
    endfunction

    task check_result(chc_pkg::pos_t position, logic is_bound, chc_pkg::val_t value,
                      logic last);
      chal_entry_t e;
      checked++;
      if (pending_entries.size() == 0) begin
        report($sformatf("unexpected result pos=%0d bound=%0b val=%0d last=%0b",
                         position, is_bound, value, last));
        return;
      end
      e = pending_entries.pop_front();
      if (position !== e.position || is_bound !== e.is_bound || value !== e.value ||
          last !== e.last) begin
        report($sformatf("result pos=%0d bound=%0b val=%0d last=%0b, want %0d %0b %0d %0b",
                         position, is_bound, value, last,
                         e.position, e.is_bound, e.value, e.last));
      end
    endtask

    task check_drained();
      if (pending_entries.size() != 0) begin
        report($sformatf("%0d results never arrived", pending_entries.size()));
      end
    endtask
  endclass

  logic          clk            = 1'b0;
  logic          rst_n          = 1'b0;
  logic          in_valid       = 1'b0;
  logic          in_ready;
  logic          in_func        = chc_pkg::FUNC_BYTE;
  logic [7:0]    in_random_byte = 8'h00;
  logic          out_valid;
  logic          out_ready      = 1'b0;
  chc_pkg::pos_t out_position;
  logic          out_is_bound;
  chc_pkg::val_t out_value;
  logic          out_last;

  chc_challenge_board board = new();
  int burst_left = 0;

  challenge_sampler_from_random_bytes dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_random_byte (in_random_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_position   (out_position),
    .out_is_bound   (out_is_bound),
    .out_value      (out_value),
    .out_last       (out_last)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) board.note_request(in_func, in_random_byte);
    if (rst_n && out_valid && out_ready) begin
      board.check_result(out_position, out_is_bound, out_value, out_last);
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(logic func, logic [7:0] data);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 100)
                                               : $urandom_range(1, 20);
    end
    burst_left--;
    in_valid       <= 1'b1;
    in_func        <= func;
    in_random_byte <= data;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Receiver: random stall modes, plus one long hold-off to back up the input.
  initial begin
    int  mode;
    int  span;
    bit  held;
    held = 1'b0;
    @(negedge clk);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 80);
      for (int i = 0; i < span; i++) begin
        if (!held && board.checked >= 70) begin
          held = 1'b1;
          out_ready <= 1'b0;
          repeat (600) @(negedge clk);
        end else begin
          case (mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= ((i % 8) < 5);
          endcase
          @(negedge clk);
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("challenge_sampler_from_random_bytes: mismatch");
    $finish;
  end

  initial begin
    int kind;
    int nbytes;
    bit noisy;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Byte straight out of reset, then a start with a full byte field.
    send_request(chc_pkg::FUNC_BYTE, 8'h5A);
    send_request(chc_pkg::FUNC_START, 8'hFF);
    // All-ones byte, then zeros complete the challenge; trailing bytes are dropped.
    send_request(chc_pkg::FUNC_BYTE, 8'hFF);
    repeat (21) send_request(chc_pkg::FUNC_BYTE, 8'h00);
    send_request(chc_pkg::FUNC_BYTE, 8'hFF);
    send_request(chc_pkg::FUNC_START, 8'h00);

    while (board.accepted < 360) begin
      kind  = $urandom_range(0, 9);
      noisy = 1'b0;
      if (kind < 8) begin
        send_request(chc_pkg::FUNC_START, 8'($urandom));
        nbytes = $urandom_range(22, 34);
      end else if (kind == 8) begin
        // cut a challenge short
        send_request(chc_pkg::FUNC_START, 8'($urandom));
        nbytes = $urandom_range(1, 15);
      end else begin
        noisy  = 1'b1;
        nbytes = $urandom_range(1, 6);
      end
      for (int i = 0; i < nbytes; i++) begin
        send_request(noisy ? logic'($urandom_range(0, 1)) : chc_pkg::FUNC_BYTE,
                     8'($urandom));
      end
    end
    in_valid <= 1'b0;

    while (board.pending_entries.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    board.check_drained();
    if (board.fails == 0) begin
      $display("challenge_sampler_from_random_bytes: match");
    end else begin
      $display("challenge_sampler_from_random_bytes: mismatch");
    end
    $finish;
  end

endmodule
